// File: src/pem_pkg.sv
`default_nettype none

package pem_pkg;

    // Pixel and field widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int ROW_W      = 12;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Defaults and limits
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_WIDTH     = 640;
    localparam int DEF_HEIGHT    = 480;
    localparam int MIN_DIM       = 3;

    // Arithmetic widths
    localparam int SUM_W  = 10;            // sum of three pixels
    localparam int GRAD_W = 11;            // signed gradient
    localparam int SQ_W   = 21;            // gx^2 + gy^2
    localparam int RAD_W  = 16;            // radicand after saturation
    localparam int ROOT_W = 8;

    localparam int SAT_LIMIT = 255;
    localparam logic [SQ_W-1:0] SAT_SQ = SQ_W'(SAT_LIMIT * SAT_LIMIT);

    typedef struct packed {
        logic center_valid;
        logic compute;
    } pem_tag_t;

endpackage

`default_nettype wire

// File: src/prewitt_edge_magnitude.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    pixel, frame_start
// output    out        out_valid / out_stall  edge_res, center_valid
// config    in         cfg_we                 cfg_index, cfg_data
//
// One pixel request per clock while in_stall is low; each accepted pixel
// yields one result via line-store read, gradients, squares and two root stages.
// The two line stores share one RAM word per column, read and written back
// once per pixel; the single RAM port pair sets the one-pixel-per-clock rate.
// Reset clears counters, window and valid bits, loads width 640, height 480.
// A stalled result freezes the whole pipe and stalls the input side.
module prewitt_edge_magnitude
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  frame_start,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [ROOT_W-1:0]     edge_res,
    output logic                       center_valid,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CMPW   = (WW > WIDTH_CFG_W) ? WW : WIDTH_CFG_W;
    localparam int WORD_W = 2 * PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_CFG_W'(DEF_WIDTH);
            height_reg <= HEIGHT_CFG_W'(DEF_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the frame size in use: width to 3..MAX_WIDTH, height to >= 3
    logic [CMPW-1:0]         w_raw;
    logic [CMPW-1:0]         w_eff;
    logic [HEIGHT_CFG_W-1:0] h_eff;

    always_comb
    begin
        w_raw = CMPW'(width_reg);
        if (w_raw > CMPW'(MAX_WIDTH))
            w_eff = CMPW'(MAX_WIDTH);
        else if (w_raw < CMPW'(MIN_DIM))
            w_eff = CMPW'(MIN_DIM);
        else
            w_eff = w_raw;
        h_eff = (height_reg < HEIGHT_CFG_W'(MIN_DIM)) ? HEIGHT_CFG_W'(MIN_DIM) : height_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic adv;
    logic accept;

    assign adv      = !(v5_reg && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;

    always_comb
    begin
        logic [COL_W-1:0] c0;
        logic [ROW_W:0]   r1;
        logic [ROW_W:0]   r_inc;

        // Restart on a frame mark, then wrap a count that a smaller size left behind
        c0 = frame_start ? '0 : col_reg;
        r1 = frame_start ? '0 : {1'b0, row_reg};
        if (CMPW'(c0) >= w_eff)
        begin
            c0 = '0;
            r1 = r1 + 1'b1;
        end
        if (r1 >= {1'b0, h_eff})
            r1 = '0;
        col_cur = c0;
        row_cur = r1[ROW_W-1:0];

        // Advance past the current pixel
        r_inc = {1'b0, row_cur} + 1'b1;
        if (CMPW'(col_cur) + 1'b1 >= w_eff)
        begin
            col_next = '0;
            row_next = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read in flight
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  px1_reg;
    logic [COL_W-1:0]  col1_reg;
    pem_tag_t          tag1_reg;
    logic              fwd1_reg;
    logic [WORD_W-1:0] fwd_word1_reg;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] wb_word;
    logic              wb_we;
    logic [PIX_W-1:0]  top1;
    logic [PIX_W-1:0]  mid1;

    // A pixel at the same column as the one being written back reads stale data:
    // forward the write-back word instead
    assign word1   = fwd1_reg ? fwd_word1_reg : ram_rdata;
    assign top1    = word1[WORD_W-1:PIX_W];
    assign mid1    = word1[PIX_W-1:0];
    assign wb_word = {mid1, px1_reg};
    assign wb_we   = adv && v1_reg;

    pem_ram #(
        .DATA_W (WORD_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (col1_reg),
        .wdata (wb_word),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px1_reg               <= pixel;
            col1_reg              <= col_cur;
            tag1_reg.center_valid <= (row_cur >= ROW_W'(1)) && (col_cur >= COL_W'(1));
            tag1_reg.compute      <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
            fwd1_reg              <= v1_reg && (col1_reg == col_cur);
            fwd_word1_reg         <= wb_word;
        end
    end

    // ------------------------------------------------------------------
    // Window: two stored columns, the third is the column just read
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] wa_reg [3];   // left column
    logic [PIX_W-1:0] wb_reg [3];   // middle column
    logic [PIX_W-1:0] wc     [3];   // right column

    assign wc[0] = top1;
    assign wc[1] = mid1;
    assign wc[2] = px1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wa_reg[i] <= '0;
                wb_reg[i] <= '0;
            end
        end
        else if (wb_we)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wa_reg[i] <= wb_reg[i];
                wb_reg[i] <= wc[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gradients
    // ------------------------------------------------------------------
    logic signed [GRAD_W-1:0] gx2_reg, gy2_reg;
    pem_tag_t                 tag2_reg;
    logic [SUM_W-1:0]         sum_left, sum_right, sum_top, sum_bot;

    assign sum_left  = SUM_W'(wa_reg[0]) + SUM_W'(wa_reg[1]) + SUM_W'(wa_reg[2]);
    assign sum_right = SUM_W'(wc[0]) + SUM_W'(wc[1]) + SUM_W'(wc[2]);
    assign sum_top   = SUM_W'(wa_reg[0]) + SUM_W'(wb_reg[0]) + SUM_W'(wc[0]);
    assign sum_bot   = SUM_W'(wa_reg[2]) + SUM_W'(wb_reg[2]) + SUM_W'(wc[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx2_reg  <= $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
            gy2_reg  <= $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
            tag2_reg <= tag1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares
    // ------------------------------------------------------------------
    logic signed [2*GRAD_W-1:0] sqx, sqy;
    logic [SQ_W-1:0]            sq3_reg;
    pem_tag_t                   tag3_reg;

    assign sqx = gx2_reg * gx2_reg;
    assign sqy = gy2_reg * gy2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq3_reg  <= SQ_W'(sqx) + SQ_W'(sqy);
            tag3_reg <= tag2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 and 5: root; saturate by clamping the radicand at 255^2,
    // force zero on border centers
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] rad;
    pem_tag_t         tag4_reg;
    logic             cv5_reg;

    assign rad = !tag3_reg.compute ? '0 :
                 (sq3_reg >= SAT_SQ) ? SAT_SQ[RAD_W-1:0] : sq3_reg[RAD_W-1:0];

    pem_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (rad),
        .root (edge_res)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag4_reg <= tag3_reg;
            cv5_reg  <= tag4_reg.center_valid;
        end
    end

    assign center_valid = cv5_reg;

    // Valid bits shift with the pipe; a bubble enters when no pixel is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;

endmodule

`default_nettype wire

// File: src/pem_ram.sv
`default_nettype none

module pem_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/pem_isqrt.sv
`default_nettype none

// Two-stage restoring square root: four root bits per stage.
module pem_isqrt
    import pem_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [RAD_W-1:0]  rad,
    output logic      [ROOT_W-1:0] root
);

    localparam int HALF_W = ROOT_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [HALF_W-1:0]  q_a_reg;
    logic [HALF_W:0]    r_a_reg;
    logic [RAD_W/2-1:0] lo_a_reg;

    logic [ROOT_W-1:0]  q_a_next;
    logic [REM_W-1:0]   r_a_next;
    logic [ROOT_W-1:0]  q_b_next;
    logic [REM_W-1:0]   r_b_next;

    // High half of the radicand
    always_comb
    begin
        logic [REM_W-1:0] r_sh;
        logic [REM_W-1:0] trial;
        q_a_next = '0;
        r_a_next = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            r_sh  = {r_a_next[REM_W-3:0], rad[RAD_W-1-2*i -: 2]};
            trial = {q_a_next, 2'b01};
            if (r_sh >= trial)
            begin
                r_a_next = r_sh - trial;
                q_a_next = {q_a_next[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r_a_next = r_sh;
                q_a_next = {q_a_next[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Low half, continuing from the stored partial root and remainder
    always_comb
    begin
        logic [REM_W-1:0] r_sh;
        logic [REM_W-1:0] trial;
        q_b_next = ROOT_W'(q_a_reg);
        r_b_next = REM_W'(r_a_reg);
        for (int i = 0; i < HALF_W; i++)
        begin
            r_sh  = {r_b_next[REM_W-3:0], lo_a_reg[RAD_W/2-1-2*i -: 2]};
            trial = {q_b_next, 2'b01};
            if (r_sh >= trial)
            begin
                r_b_next = r_sh - trial;
                q_b_next = {q_b_next[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r_b_next = r_sh;
                q_b_next = {q_b_next[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_a_reg  <= q_a_next[HALF_W-1:0];
            r_a_reg  <= r_a_next[HALF_W:0];
            lo_a_reg <= rad[RAD_W/2-1:0];
            root     <= q_b_next;
        end
    end

endmodule

`default_nettype wire

// File: test/pem_edge_checker.sv
module pem_edge_checker
    import pem_pkg::*;
#(
    parameter int MAX_W = DEF_MAX_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [ROOT_W-1:0]     edge_res,
    input  logic                  center_valid,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [ROOT_W-1:0] mag;
        logic              center;
    } edge_item_t;

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [PIX_W-1:0]        row_above  [MAX_W];
    logic [PIX_W-1:0]        row_two_up [MAX_W];
    logic [PIX_W-1:0]        win        [3][3];
    int unsigned             col_pos;
    int unsigned             row_pos;
    edge_item_t              edge_queue [$];
    edge_item_t              want;

    // Largest 8-bit r with r*r <= v; saturates at 255 by construction.
    function automatic logic [ROOT_W-1:0] floor_root(int unsigned v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (ROOT_W'(1) << b);
            if (32'(t) * 32'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic edge_item_t edge_of_pixel(logic [PIX_W-1:0] px, logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int          gx;
        int          gy;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        edge_item_t  r;
        w = width_reg;
        h = height_reg;
        if (w > MAX_W)
            w = MAX_W;
        if (w < MIN_DIM)
            w = MIN_DIM;
        if (h < MIN_DIM)
            h = MIN_DIM;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        // wrap positions left past a shrunken limit
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        col = col_pos;
        row = row_pos;

        up2 = row_two_up[col];
        up1 = row_above[col];
        row_two_up[col] = up1;
        row_above[col]  = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2;
        win[1][2] = up1;
        win[2][2] = px;

        r.mag = '0;
        if (row >= 2 && col >= 2)
        begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++)
            begin
                gx += int'(win[i][2]) - int'(win[i][0]);
                gy += int'(win[0][i]) - int'(win[2][i]);
            end
            r.mag = floor_root(gx * gx + gy * gy);
        end
        r.center = (row >= 1 && col >= 1);

        col_pos = col + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h)
                row_pos = 0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_CFG_W'(DEF_WIDTH);
            height_reg = HEIGHT_CFG_W'(DEF_HEIGHT);
            col_pos    = 0;
            row_pos    = 0;
            for (int i = 0; i < MAX_W; i++)
            begin
                row_above[i]  = '0;
                row_two_up[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            edge_queue.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[WIDTH_CFG_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[HEIGHT_CFG_W-1:0];
            end
            // retire before predicting so a stray result cannot match a fresh request
            if (out_valid && !out_stall)
            begin
                if (edge_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: edge_res %0d center_valid %0b",
                             $time, edge_res, center_valid);
                end
                else
                begin
                    want = edge_queue.pop_front();
                    if (edge_res !== want.mag)
                    begin
                        errors++;
                        $display("%0t: edge_res expected %0d, actual %0d",
                                 $time, want.mag, edge_res);
                    end
                    if (center_valid !== want.center)
                    begin
                        errors++;
                        $display("%0t: center_valid expected %0b, actual %0b",
                                 $time, want.center, center_valid);
                    end
                end
            end
            if (in_valid && !in_stall)
                edge_queue.push_back(edge_of_pixel(pixel, frame_start));
            pending = edge_queue.size();
        end
    end

endmodule

// File: test/tb_top.sv
module tb_top;
    import pem_pkg::*;

    // Run bounds
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SMALL_ITEMS  = 1350;     // pixel requests over all random phases
    localparam int WIDE_ITEMS   = 1030;     // one pass past the widest row
    localparam int HOLD_CYCLES  = 64;       // receiver hold-off for back pressure
    localparam int TAIL_CYCLES  = 12;       // pipe is five deep

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall;
    logic [ROOT_W-1:0]     edge_res;
    logic                  center_valid;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   errors;
    int   pending;
    int   sent   = 0;      // requests accepted so far
    int   cycles = 0;
    logic burst  = 1'b0;   // sender offers back to back while set
    int   cur_width = DEF_WIDTH;

    // Directed frames, 3x3 raster order.
    // Left column dark, right column bright: horizontal gradient saturates.
    logic [PIX_W-1:0] sat_frame [9] = '{8'd0, 8'd128, 8'd255,
                                        8'd0, 8'd128, 8'd255,
                                        8'd0, 8'd255, 8'd255};
    // Negative horizontal, positive vertical gradient: magnitude 116.
    logic [PIX_W-1:0] mix_frame [9] = '{8'd70, 8'd60, 8'd50,
                                        8'd40, 8'd40, 8'd40,
                                        8'd90, 8'd20, 8'd10};

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    prewitt_edge_magnitude dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_res     (edge_res),
        .center_valid (center_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pem_edge_checker edge_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_res     (edge_res),
        .center_valid (center_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    // Stop a hung run: nothing correct comes close to this many cycles.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Width the block actually uses for a raw register value.
    function automatic int eff_width(int value);
        int v;
        v = value % (1 << WIDTH_CFG_W);
        if (v > DEF_MAX_WIDTH)
            v = DEF_MAX_WIDTH;
        if (v < MIN_DIM)
            v = MIN_DIM;
        return v;
    endfunction

    // Write one register; called at a falling edge, returns at the next one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Offer one pixel request after a random idle stretch. Valid stays high on
    // return so that a zero gap next time keeps the stream back to back.
    task automatic push_pixel(input logic [PIX_W-1:0] px, input logic fs);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        pixel       = px;
        frame_start = fs;
        // hold the payload until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding result come back. Each request
    // yields exactly one result, so an empty queue means an empty pipe.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Reprogram the frame size while idle. Growing past the width in use
    // would read line-store columns never filled in this frame, so restart.
    task automatic set_frame(input int w_val, input int h_val, output logic restart);
        settle();
        write_reg(REG_IMAGE_WIDTH, w_val);
        write_reg(REG_IMAGE_HEIGHT, h_val);
        restart   = eff_width(w_val) > cur_width;
        cur_width = eff_width(w_val);
    endtask

    // One phase: new frame size, then a stream of pixel requests. Most of it is
    // plain raster stream; a stray frame_start now and then breaks a frame.
    task automatic run_phase(input int w_val, input int h_val, input int n);
        logic             restart;
        logic             fs;
        int               style;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] px;
        set_frame(w_val, h_val, restart);
        style = $urandom_range(0, 2);
        burst = ($urandom_range(0, 3) == 0);
        base  = PIX_W'($urandom);
        for (int k = 0; k < n; k++)
        begin
            // without a restart the old position carries over and may wrap
            if (k == 0)
                fs = restart || ($urandom_range(0, 2) == 0);
            else
                fs = ($urandom_range(0, 149) == 0);
            case (style)
                0:       px = PIX_W'($urandom);
                1:       px = PIX_W'(base + $urandom_range(0, 15));
                default: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            push_pixel(px, fs);
        end
        burst = 1'b0;
    endtask

    // Receiver: random stall stretches, quiet spells, and two long hold-offs
    // while the sender keeps offering, so the pipe fills and in_stall rises.
    initial
    begin
        int holds;
        int run;
        holds     = 0;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            if (holds < 2 && sent >= 300 + 700 * holds)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds++;
            end
            else
            begin
                run = pick_gap();
                if (run > 0)
                begin
                    out_stall = 1'b1;
                    repeat (run) @(negedge clk);
                end
                out_stall = 1'b0;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(20, 40)) @(negedge clk);
                else
                    repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic restart;
        int   total;
        int   phase;
        int   n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        pixel       = '0;
        frame_start = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: smallest legal frame. Saturating frame, then a frame
        // reached by wrap alone, then a frame broken off by frame_start.
        set_frame(MIN_DIM, MIN_DIM, restart);
        for (int i = 0; i < 9; i++)
            push_pixel(sat_frame[i], i == 0);
        for (int i = 0; i < 9; i++)
            push_pixel(mix_frame[i], 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'hFF, 1'b0);
        push_pixel(8'h00, 1'b1);
        push_pixel(8'h81, 1'b0);

        // Random phases. The first few pin the register extremes: values
        // below the minimum, the tallest frame, and a width past the line
        // store that clamps to the widest row.
        total = 0;
        phase = 0;
        while (total < SMALL_ITEMS)
        begin
            n = $urandom_range(20, 60);
            if (phase == 3)
                n = WIDE_ITEMS;
            else if (phase == 4)
                n = 40;
            case (phase)
                0: run_phase(0, 1, n);
                1: run_phase(2, 2, n);
                2: run_phase(7, 4095, n);
                3: run_phase(4095, 0, n);
                4: run_phase(DEF_MAX_WIDTH, 5, n);
                default:
                begin
                    if ($urandom_range(0, 5) == 0)
                        run_phase($urandom_range(0, 2), $urandom_range(0, 8), n);
                    else
                        run_phase($urandom_range(3, 24), $urandom_range(0, 8), n);
                end
            endcase
            total += n;
            phase++;
        end

        // Wait for the last results, then give the pipe time to show strays.
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
